### hdl/tgcft_pkg.sv
package tgcft_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_SWING   = 3'd1;
    localparam logic [2:0] CFG_X_START = 3'd2;
    localparam logic [2:0] CFG_X_END   = 3'd3;
    localparam logic [2:0] CFG_Y_START = 3'd4;
    localparam logic [2:0] CFG_Y_END   = 3'd5;

    // gait phase codes
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    // coordinate axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] LEG_LAST = 2'd3;
    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef struct packed {
        logic        [15:0] time_tick;
        logic signed [15:0] roll_angle;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] leg1_x;
        logic signed [15:0] leg1_y;
        logic signed [15:0] leg1_z;
        logic signed [15:0] leg2_x;
        logic signed [15:0] leg2_y;
        logic signed [15:0] leg2_z;
        logic signed [15:0] leg3_x;
        logic signed [15:0] leg3_y;
        logic signed [15:0] leg3_z;
        logic signed [15:0] leg4_x;
        logic signed [15:0] leg4_y;
        logic signed [15:0] leg4_z;
    } out_item_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_IDX,
        MUL_SIN,
        MUL_ROLL,
        MUL_LO,
        MUL_HI,
        MUL_Z
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     div_step;
        mul_sel_t mul_sel;
        logic     tab_load;
        logic     cyc_load;
        logic     hgt_load;
        logic     acc_load;
        logic     wr;
        logic [1:0] leg;
        logic [1:0] axis;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic phase_none;
    } dp_status_t;

endpackage

### hdl/trot_gait_cycloid_foot_trajectory.sv
// Sequence: for an item inside the gait cycle, a restoring divide of 32 quotient
//   bits, 5 table and multiply steps, then a low multiply, a high multiply and a
//   write per coordinate on one shared multiplier, then the result load; a tick
//   that holds goes straight from the divide state to the result load.
// Items: a new input is not taken until the previous item is through; the next
//   input transfer is taken while a finished result still waits on out_stall.
// Reset: control and configuration registers take their reset values, held positions clear to zero.
module trot_gait_cycloid_foot_trajectory
    import tgcft_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int COORD_WIDTH      = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    tgcft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tgcft_dp #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .COORD_WIDTH      (COORD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### hdl/tgcft_ctrl.sv
module tgcft_ctrl
    import tgcft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_DIV  = 11'b00000000010,
        S_MIDX = 11'b00000000100,
        S_TAB  = 11'b00000001000,
        S_MSIN = 11'b00000010000,
        S_CYC  = 11'b00000100000,
        S_HGT  = 11'b00001000000,
        S_LO   = 11'b00010000000,
        S_HI   = 11'b00100000000,
        S_WR   = 11'b01000000000,
        S_DONE = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] div_cnt_reg, div_cnt_next;
    logic [1:0] leg_reg, leg_next;
    logic [1:0] axis_reg, axis_next;
    logic       out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // sequence the steps of one item
    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        leg_next       = leg_reg;
        axis_next      = axis_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_NONE;
        cmd.leg        = leg_reg;
        cmd.axis       = axis_reg;

        // drop the result once its transfer completes
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    div_cnt_next = '0;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.phase_none)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    div_cnt_next = div_cnt_reg + 5'd1;
                    if (div_cnt_reg == DIV_LAST)
                    begin
                        state_next = S_MIDX;
                    end
                end
            end
            S_MIDX:
            begin
                cmd.mul_sel = MUL_IDX;
                state_next  = S_TAB;
            end
            S_TAB:
            begin
                cmd.tab_load = 1'b1;
                state_next   = S_MSIN;
            end
            S_MSIN:
            begin
                cmd.mul_sel = MUL_SIN;
                state_next  = S_CYC;
            end
            S_CYC:
            begin
                cmd.cyc_load = 1'b1;
                cmd.mul_sel  = MUL_ROLL;
                state_next   = S_HGT;
            end
            S_HGT:
            begin
                cmd.hgt_load = 1'b1;
                leg_next     = '0;
                axis_next    = AXIS_X;
                state_next   = S_LO;
            end
            S_LO:
            begin
                cmd.mul_sel = (axis_reg == AXIS_Z) ? MUL_Z : MUL_LO;
                state_next  = S_HI;
            end
            S_HI:
            begin
                cmd.acc_load = 1'b1;
                cmd.mul_sel  = MUL_HI;
                state_next   = S_WR;
            end
            S_WR:
            begin
                cmd.wr     = 1'b1;
                state_next = S_LO;
                if (axis_reg == AXIS_Z)
                begin
                    axis_next = AXIS_X;
                    leg_next  = leg_reg + 2'd1;
                    if (leg_reg == LEG_LAST)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            div_cnt_reg   <= '0;
            leg_reg       <= '0;
            axis_reg      <= AXIS_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            leg_reg       <= leg_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/tgcft_dp.sv
module tgcft_dp
    import tgcft_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int COORD_WIDTH      = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_item_t    in_data,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  dp_cmd_t     cmd,
    output dp_status_t  status
);

    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam logic signed [28:0] INV_TWO_PI = 29'sd170891318;
    localparam logic signed [28:0] COEF_035   = 29'sd22938;
    localparam logic signed [17:0] LIFT_BASE  = 18'sd5120;
    localparam logic signed [15:0] STANCE_Z_ONE = -16'sd1280;
    localparam logic signed [15:0] STANCE_Z_TWO = -16'sd768;
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] HALF_PI = 64'd1686629713;

    // one sine entry in Q14 from a Q30 odd series on the first quadrant
    function automatic logic signed [15:0] sine_entry(input logic [31:0] k);
        logic [63:0] p;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] acc;
        logic [63:0] s;
        p    = ({32'd0, k} << 32) / SINE_TABLE_DEPTH;
        quad = (p >> 30) & 64'd3;
        r    = p & (Q30_ONE - 64'd1);
        a    = quad[0] ? (Q30_ONE - r) : r;
        x    = (a * HALF_PI) >> 30;
        x2   = (x * x) >> 30;
        acc  = Q30_ONE;
        acc  = Q30_ONE - ((x2 * acc) >> 30) / 64'd156;
        acc  = Q30_ONE - ((x2 * acc) >> 30) / 64'd110;
        acc  = Q30_ONE - ((x2 * acc) >> 30) / 64'd72;
        acc  = Q30_ONE - ((x2 * acc) >> 30) / 64'd42;
        acc  = Q30_ONE - ((x2 * acc) >> 30) / 64'd20;
        acc  = Q30_ONE - ((x2 * acc) >> 30) / 64'd6;
        s    = (x * acc) >> 30;
        s    = (s + 64'd32768) >> 16;
        return quad[1] ? -$signed(16'(s)) : $signed(16'(s));
    endfunction

    function automatic logic [15:0] saturate(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = v;
        if (c > SAT_HI)
        begin
            c = SAT_HI;
        end
        if (c < SAT_LO)
        begin
            c = SAT_LO;
        end
        return c[15:0];
    endfunction

    logic signed [15:0] sin_rom [SINE_TABLE_DEPTH];

    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++)
    begin : g_rom
        assign sin_rom[g] = sine_entry(32'(g));
    end

    // configuration
    logic [15:0] period_reg, swing_reg;
    logic [63:0] xs_reg, xe_reg, ys_reg, ye_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= 16'd1000;
            swing_reg  <= 16'd500;
            xs_reg     <= '0;
            xe_reg     <= '0;
            ys_reg     <= '0;
            ye_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PERIOD:  period_reg <= cfg_data[15:0];
                CFG_SWING:   swing_reg  <= cfg_data[15:0];
                CFG_X_START: xs_reg     <= cfg_data;
                CFG_X_END:   xe_reg     <= cfg_data;
                CFG_Y_START: ys_reg     <= cfg_data;
                CFG_Y_END:   ye_reg     <= cfg_data;
                default:     ;
            endcase
        end
    end

    // datapath registers
    logic [1:0]         phase_reg;
    logic signed [15:0] roll_reg;
    logic [31:0]        quo_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        dvs_reg;
    logic signed [15:0] s14_reg, c14_reg;
    logic signed [34:0] cyc_reg;
    logic signed [16:0] w15_reg;
    logic signed [17:0] h12_reg, h34_reg;
    logic signed [46:0] prod_reg, prod_next;
    logic signed [46:0] acc_reg;
    logic [15:0]        held_reg [12];
    out_item_t          out_reg;

    assign status.phase_none = (phase_reg == PH_NONE);
    assign out_data          = out_reg;

    // phase and division operand at accept
    logic [1:0]  phase_in;
    logic [15:0] dt_in;

    always_comb
    begin
        if (in_data.time_tick <= swing_reg)
        begin
            phase_in = PH_ONE;
            dt_in    = in_data.time_tick;
        end
        else if (in_data.time_tick < period_reg)
        begin
            phase_in = PH_TWO;
            dt_in    = in_data.time_tick - swing_reg;
        end
        else
        begin
            phase_in = PH_NONE;
            dt_in    = '0;
        end
    end

    // restoring divide, one quotient bit a cycle
    logic [16:0] shifted;
    logic        q_bit;

    assign shifted = {rem_reg, quo_reg[31]};
    assign q_bit   = (shifted >= {1'b0, dvs_reg});

    // table lookup
    logic [IDX_W-1:0] idx;
    logic [IDX_W:0]   cidx_sum;
    logic [IDX_W-1:0] cidx;

    assign idx      = prod_reg[16 +: IDX_W];
    assign cidx_sum = {1'b0, idx} + (IDX_W + 1)'(QUARTER);
    assign cidx     = (cidx_sum >= (IDX_W + 1)'(SINE_TABLE_DEPTH))
                    ? IDX_W'(cidx_sum - (IDX_W + 1)'(SINE_TABLE_DEPTH))
                    : IDX_W'(cidx_sum);

    // current leg and coordinate
    logic               swinging;
    logic signed [15:0] lane_s, lane_e, base, other;
    logic signed [16:0] diff;
    logic signed [17:0] h_sel;
    logic [3:0]         wr_idx;

    assign swinging = ((phase_reg == PH_ONE) == (cmd.leg[0] == 1'b0));
    assign lane_s   = (cmd.axis == AXIS_X) ? $signed(xs_reg[16 * cmd.leg +: 16])
                                           : $signed(ys_reg[16 * cmd.leg +: 16]);
    assign lane_e   = (cmd.axis == AXIS_X) ? $signed(xe_reg[16 * cmd.leg +: 16])
                                           : $signed(ye_reg[16 * cmd.leg +: 16]);
    assign base     = swinging ? lane_s : lane_e;
    assign other    = swinging ? lane_e : lane_s;
    assign diff     = 17'(other) - 17'(base);
    assign h_sel    = cmd.leg[1] ? h34_reg : h12_reg;
    assign wr_idx   = 4'(cmd.leg) * 4'd3 + 4'(cmd.axis);

    // shared multiplier
    logic signed [28:0] mul_a;
    logic signed [17:0] mul_b;

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_IDX:
            begin
                mul_a = 29'(SINE_TABLE_DEPTH);
                mul_b = $signed({2'b00, quo_reg[15:0]});
            end
            MUL_SIN:
            begin
                mul_a = INV_TWO_PI;
                mul_b = 18'(s14_reg);
            end
            MUL_ROLL:
            begin
                mul_a = COEF_035;
                mul_b = 18'(roll_reg);
            end
            MUL_LO:
            begin
                mul_a = 29'($signed({1'b0, cyc_reg[16:0]}));
                mul_b = 18'(diff);
            end
            MUL_HI:
            begin
                mul_a = 29'($signed(cyc_reg[34:17]));
                mul_b = 18'(diff);
            end
            MUL_Z:
            begin
                mul_a = 29'(h_sel);
                mul_b = 18'(w15_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 47'(mul_a) * 47'(mul_b);

    // coordinate result
    logic signed [63:0] total, pos_val, z_val;
    logic [15:0]        coord_val;

    assign total   = (64'(prod_reg) <<< 17) + 64'(acc_reg);
    assign pos_val = 64'(base) + (total >>> 16);
    assign z_val   = swinging ? (64'(acc_reg) >>> 15)
                   : ((phase_reg == PH_ONE) ? 64'(STANCE_Z_ONE) : 64'(STANCE_Z_TWO));
    assign coord_val = (cmd.axis == AXIS_Z) ? saturate(z_val) : saturate(pos_val);

    // control-bearing item state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NONE;
            for (int i = 0; i < 12; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                phase_reg <= phase_in;
            end
            if (cmd.wr)
            begin
                held_reg[wr_idx] <= coord_val;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            roll_reg <= in_data.roll_angle;
            quo_reg  <= {dt_in, 16'd0};
            rem_reg  <= '0;
            dvs_reg  <= (swing_reg == 16'd0) ? 16'd1 : swing_reg;
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? 16'(shifted - {1'b0, dvs_reg}) : shifted[15:0];
            quo_reg <= {quo_reg[30:0], q_bit};
        end
        if (cmd.mul_sel != MUL_NONE)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.tab_load)
        begin
            s14_reg <= sin_rom[idx];
            c14_reg <= sin_rom[cidx];
        end
        if (cmd.cyc_load)
        begin
            cyc_reg <= 35'($signed({1'b0, quo_reg})) - 35'(prod_reg >>> 28);
            w15_reg <= 17'sd16384 - 17'(c14_reg);
        end
        if (cmd.hgt_load)
        begin
            h12_reg <= LIFT_BASE - 18'(roll_reg >>> 1);
            h34_reg <= LIFT_BASE + 18'(prod_reg >>> 16);
        end
        if (cmd.acc_load)
        begin
            acc_reg <= prod_reg;
        end
        if (cmd.out_load)
        begin
            out_reg <= {held_reg[0], held_reg[1], held_reg[2],
                        held_reg[3], held_reg[4], held_reg[5],
                        held_reg[6], held_reg[7], held_reg[8],
                        held_reg[9], held_reg[10], held_reg[11]};
        end
    end

endmodule

### sim/trot_gait_checker.sv
`timescale 1ns / 100ps

module foot_trajectory_checker
    import tgcft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_item_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_item_t   out_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int TAB_DEPTH = 256;
    localparam longint LIFT_BASE = 5120;
    localparam longint INV_TWO_PI_Q30 = 170891318;
    localparam longint COEF_035_Q16 = 22938;
    localparam longint STANCE_Z_ONE = -1280;
    localparam longint STANCE_Z_TWO = -768;

    longint      sine_q14 [TAB_DEPTH];
    logic [15:0] gait_period;
    logic [15:0] gait_swing;
    logic [63:0] x_start, x_end, y_start, y_end;
    logic [15:0] held_pos [12];
    out_item_t   expected_q [$];

    // Q30 Taylor series on the first quadrant, rounded to Q14
    function automatic longint sine_value(longint unsigned k);
        longint unsigned divs [6];
        longint unsigned one_q30, p, quad, r, a, x, x2, acc, s;
        one_q30 = 64'd1 << 30;
        divs = '{156, 110, 72, 42, 20, 6};
        p = (k << 32) / TAB_DEPTH;
        quad = (p >> 30) & 3;
        r = p & (one_q30 - 1);
        a = quad[0] ? (one_q30 - r) : r;
        x = (a * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        acc = one_q30;
        for (int i = 0; i < 6; i++)
            acc = one_q30 - ((x2 * acc) >> 30) / divs[i];
        s = (x * acc) >> 30;
        s = (s + (64'd1 << 15)) >> 16;
        return (quad >= 2) ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint lane_of(logic [63:0] packed_val, int leg);
        logic signed [15:0] v;
        v = packed_val[16*leg +: 16];
        return longint'(v);
    endfunction

    function automatic logic [15:0] clamp16(longint v);
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v[15:0];
    endfunction

    // Work out leg targets for one tick and update the held positions
    function automatic out_item_t predict_legs(in_item_t it);
        longint    tick, roll, divisor, dt, uq, idx, cidx, s14, c14, cyc, w15, h12, h34, h;
        longint    xs, xe, ys, ye, px, py, pz;
        logic [1:0] phase;
        logic      swinging;
        tick = longint'(it.time_tick);
        roll = longint'(it.roll_angle);
        divisor = (gait_swing == 0) ? 1 : longint'(gait_swing);
        phase = PH_NONE;
        dt = 0;
        if (tick <= longint'(gait_swing))
        begin
            phase = PH_ONE;
            dt = tick;
        end
        else if (tick < longint'(gait_period))
        begin
            phase = PH_TWO;
            dt = tick - longint'(gait_swing);
        end
        if (phase != PH_NONE)
        begin
            uq = (dt << 16) / divisor;
            idx = (((uq & 64'hFFFF) * TAB_DEPTH) >> 16) % TAB_DEPTH;
            cidx = (idx + TAB_DEPTH / 4) % TAB_DEPTH;
            s14 = sine_q14[idx];
            c14 = sine_q14[cidx];
            cyc = uq - ((s14 * INV_TWO_PI_Q30) >>> 28);
            w15 = 16384 - c14;
            h12 = LIFT_BASE - (roll >>> 1);
            h34 = LIFT_BASE + ((roll * COEF_035_Q16) >>> 16);
            for (int leg = 0; leg < 4; leg++)
            begin
                xs = lane_of(x_start, leg);
                xe = lane_of(x_end, leg);
                ys = lane_of(y_start, leg);
                ye = lane_of(y_end, leg);
                swinging = (phase == PH_ONE) == (leg % 2 == 0);
                if (swinging)
                begin
                    h = (leg < 2) ? h12 : h34;
                    px = xs + (((xe - xs) * cyc) >>> 16);
                    py = ys + (((ye - ys) * cyc) >>> 16);
                    pz = (h * w15) >>> 15;
                end
                else
                begin
                    px = xe + (((xs - xe) * cyc) >>> 16);
                    py = ye + (((ys - ye) * cyc) >>> 16);
                    pz = (phase == PH_ONE) ? STANCE_Z_ONE : STANCE_Z_TWO;
                end
                held_pos[leg*3 + AXIS_X] = clamp16(px);
                held_pos[leg*3 + AXIS_Y] = clamp16(py);
                held_pos[leg*3 + AXIS_Z] = clamp16(pz);
            end
        end
        return {held_pos[0], held_pos[1], held_pos[2], held_pos[3], held_pos[4],
                held_pos[5], held_pos[6], held_pos[7], held_pos[8], held_pos[9],
                held_pos[10], held_pos[11]};
    endfunction

    initial
    begin
        for (int k = 0; k < TAB_DEPTH; k++)
            sine_q14[k] = sine_value(k);
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t   want;
        logic [15:0] exp_f, act_f;
        string       axis_name;
        if (!rst_n)
        begin
            gait_period = 16'd1000;
            gait_swing = 16'd500;
            x_start = '0;
            x_end = '0;
            y_start = '0;
            y_end = '0;
            for (int j = 0; j < 12; j++)
                held_pos[j] = '0;
            expected_q.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PERIOD:  gait_period = cfg_data[15:0];
                    CFG_SWING:   gait_swing = cfg_data[15:0];
                    CFG_X_START: x_start = cfg_data;
                    CFG_X_END:   x_end = cfg_data;
                    CFG_Y_START: y_start = cfg_data;
                    CFG_Y_END:   y_end = cfg_data;
                    default:     ;
                endcase
            end
            // compare the result transfer against the oldest expectation
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result transfer with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    for (int j = 0; j < 12; j++)
                    begin
                        exp_f = want[191 - 16*j -: 16];
                        act_f = out_data[191 - 16*j -: 16];
                        axis_name = (j % 3 == AXIS_X) ? "x" : (j % 3 == AXIS_Y) ? "y" : "z";
                        if (exp_f !== act_f)
                        begin
                            $error("leg%0d_%s expected %0d actual %0d", j / 3 + 1, axis_name,
                                   $signed(exp_f), $signed(act_f));
                            fail_count++;
                        end
                    end
                end
            end
            // predict the input transfer
            if (in_valid && !in_stall)
                expected_q.push_back(predict_legs(in_data));
            pending = expected_q.size();
        end
    end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tgcft_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd6;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int ITEMS_PER_SET = 115;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending;

    int          send_idle_pct;
    int          recv_idle_pct;
    logic        hold_go;
    int          hold_left;
    logic        hold_taken;
    int          quiet_cycles;
    logic [15:0] cur_period;

    trot_gait_cycloid_foot_trajectory DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    foot_trajectory_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
        clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Stall the result side at random, or for one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_taken <= 1'b0;
        end
        else if (hold_go && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // End the run if no transfer happens for too long
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall)
                 || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_gait(logic [15:0] per, logic [15:0] sw,
                             logic [63:0] xs, logic [63:0] xe,
                             logic [63:0] ys, logic [63:0] ye);
        write_reg(CFG_PERIOD, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | per);
        write_reg(CFG_SWING, {48'h0, sw});
        write_reg(CFG_X_START, xs);
        write_reg(CFG_X_END, xe);
        write_reg(CFG_Y_START, ys);
        write_reg(CFG_Y_END, ye);
        // unused index is ignored
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        cur_period = per;
    endtask

    task automatic send_tick(logic [15:0] tick, logic [15:0] roll);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{time_tick: tick, roll_angle: roll};
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Let every expected result drain, then allow the pipeline to settle
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_lanes(bit wide);
        logic [63:0] v;
        for (int k = 0; k < 4; k++)
            v[16*k +: 16] = wide ? 16'($urandom) : 16'($urandom_range(51200) - 25600);
        return v;
    endfunction

    function automatic logic [15:0] rand_roll();
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($urandom_range(10240) - 5120);
        endcase
    endfunction

    function automatic logic [15:0] rand_tick();
        int top;
        top = (cur_period == 0) ? 0 : int'(cur_period);
        case ($urandom_range(9))
            0:       return 16'($urandom);
            1:       return 16'(top);
            default: return 16'($urandom_range(top > 0 ? top - 1 : 0));
        endcase
    endfunction

    task automatic random_gait();
        logic [15:0] per, sw;
        bit wide;
        case ($urandom_range(5))
            0:
            begin
                per = 16'hFFFF;
                sw = 16'hFFFF;
            end
            1:
            begin
                per = 16'($urandom_range(2000, 200));
                sw = 16'($urandom_range(int'(per) / 3, 1));
            end
            default:
            begin
                per = 16'($urandom_range(4000, 2));
                sw = 16'($urandom_range(int'(per), 1));
            end
        endcase
        wide = ($urandom_range(3) == 0);
        load_gait(per, sw, rand_lanes(wide), rand_lanes(wide), rand_lanes(wide),
                  rand_lanes(wide));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PERIOD;
        cfg_data = '0;
        hold_go = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cur_period = 16'd1000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: zero positions, phase boundaries, roll extremes
        send_tick(16'd0, 16'h0000);
        send_tick(16'd250, 16'h7FFF);
        send_tick(16'd500, 16'h8000);
        send_tick(16'd501, 16'hFFFF);
        send_tick(16'd999, 16'h0100);
        send_tick(16'd1000, 16'h0000);
        drain_results();

        // default gait with positions at lane extremes
        load_gait(16'd1000, 16'd500, 64'h7FFF_8000_7FFF_8000, 64'h8000_7FFF_8000_7FFF,
                  64'h1234_EDCC_0A00_F600, 64'hF000_1000_8000_7FFF);
        send_tick(16'd0, 16'h8000);
        send_tick(16'd125, 16'h7FFF);
        send_tick(16'd500, 16'h0000);
        send_tick(16'd750, 16'hFFFF);
        send_tick(16'd1000, 16'h1400);
        send_tick(16'hFFFF, 16'h0000);
        drain_results();

        // long phase two keeps the cycloid growing past one
        load_gait(16'd60000, 16'd100, rand_lanes(1'b0), rand_lanes(1'b0), rand_lanes(1'b0),
                  rand_lanes(1'b0));
        send_tick(16'd100, 16'h0000);
        send_tick(16'd5000, 16'h0A00);
        send_tick(16'd59999, 16'hF600);
        drain_results();

        // zero swing and zero period
        load_gait(16'd0, 16'd0, rand_lanes(1'b1), rand_lanes(1'b1), rand_lanes(1'b1),
                  rand_lanes(1'b1));
        send_tick(16'd0, 16'h0300);
        send_tick(16'd1, 16'h0000);
        drain_results();

        // widest registers: every tick in phase one
        load_gait(16'hFFFF, 16'hFFFF, rand_lanes(1'b1), rand_lanes(1'b1), rand_lanes(1'b1),
                  rand_lanes(1'b1));
        send_tick(16'hFFFF, 16'h8000);
        send_tick(16'h8000, 16'h7FFF);
        send_tick(16'h5555, 16'hAAAA);
        send_tick(16'hAAAA, 16'h5555);
        drain_results();

        // random traffic in three idling profiles
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 56 : 0;
            recv_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 30 : 0;
            for (int set_n = 0; set_n < 2; set_n++)
            begin
                random_gait();
                // fill the block behind a long receiver hold-off
                if (ph == 2 && set_n == 0)
                    hold_go <= 1'b1;
                for (int n = 0; n < ITEMS_PER_SET; n++)
                    send_tick(rand_tick(), rand_roll());
                drain_results();
            end
        end

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
